[rtl/blsd_pkg.sv]
// Shared types and codes for the bounded list with search and delete.
`default_nettype none

package blsd_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;

  // Request modes
  localparam logic [2:0] MODE_PUSH_HEAD = 3'd0;
  localparam logic [2:0] MODE_PUSH_TAIL = 3'd1;
  localparam logic [2:0] MODE_POP_HEAD  = 3'd2;
  localparam logic [2:0] MODE_POP_TAIL  = 3'd3;
  localparam logic [2:0] MODE_DELETE    = 3'd4;
  localparam logic [2:0] MODE_CONTAINS  = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic                     found;
    logic [1:0]               status;
    logic [4:0]               count;
  } rsp_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,        // keep contents
    OP_SHIFT_UP,    // take left neighbor's entry (push at head)
    OP_SHIFT_DOWN,  // take right neighbor's entry (pop from head)
    OP_WRITE_TAIL,  // cell at index count takes the key
    OP_SCAN_START,  // place the search token on cell 0
    OP_SCAN_STEP,   // test and hand the token to the right
    OP_DEL_SHIFT    // close the gap at the matched cell
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/blsd_chan_if.sv]
// Valid/ready channel carrying one payload per transfer.
`default_nettype none

interface blsd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/blsd_cell.sv]
// One list slot: holds an entry, moves it to a neighbor, tests it against the key.
`default_nettype none

module blsd_cell
  import blsd_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctl_t         ctl,
  input  wire logic [CW-1:0]     count,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  input  wire logic              tok_in,
  input  wire logic              passed_right,
  output logic [DATA_W-1:0]      data,
  output logic                   tok,
  output logic                   passed,
  output logic                   hit,
  output logic [DATA_W-1:0]      tail_data
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);
  localparam logic          IS_HEAD = (IDX == 0);

  logic valid;

  assign valid     = (IDX_C < count);
  assign hit       = tok & valid & (data == ctl.key);
  assign tail_data = (IDX_P1 == count) ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok    <= 1'b0;
      passed <= 1'b0;
    end else begin
      case (ctl.op)
        OP_SCAN_START: begin
          tok    <= IS_HEAD;
          passed <= 1'b0;
        end
        OP_SCAN_STEP: begin
          tok    <= tok_in;
          passed <= passed | tok;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_SHIFT_UP:   data <= left_data;
      OP_SHIFT_DOWN: data <= right_data;
      OP_WRITE_TAIL: begin
        if (IDX_C == count) data <= ctl.key;
      end
      // matched cell is the last one passed; it and all cells after it move down
      OP_DEL_SHIFT: begin
        if (!passed || !passed_right) data <= right_data;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/bounded_list_with_search_delete.sv]
// Top level: ordered list of signed 32-bit entries held in a chain of cells.
//
// Usage
//   req: valid/ready channel carrying mode and value; a transfer happens at a
//        rising edge with valid and ready both high.
//   rsp: valid/ready channel carrying out_value, found, status and count; one
//        result per request, in request order.
// Sequencing
//   Push head, push tail, pop head and pop tail need no search: the result is
//   valid the cycle after the request transfer, and while results are taken a
//   new request may follow at once, so these run at one item per cycle.
//   Contains and delete pass a search token along the cells from the head,
//   testing entries up to the first match, or every entry (up to DEPTH) when
//   nothing matches; on a match, a delete then closes the gap in state S_DEL.
//   The token advances one cell a cycle. An empty list needs no search.
// Reset
//   rst (synchronous) empties the list and drops any pending result; entry
//   contents are not cleared and are never observed before written.
// Stalls
//   The result sits in an output register until taken; req.ready stays low
//   while a result waits and is not being taken, or while a search runs.
`default_nettype none

module bounded_list_with_search_delete
  import blsd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  blsd_chan_if.sink   req,
  blsd_chan_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DEL
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  steps, steps_next;
  logic [DATA_W-1:0] key;
  logic           is_del;
  logic           rsp_valid;
  rsp_t           rsp_data;

  logic           accept;
  logic           done;
  rsp_t           res;
  cell_ctl_t      ctl;
  logic           full, empty;
  logic           hit_any;
  logic [DATA_W-1:0] tail_any;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_tail [DEPTH];
  logic [DEPTH-1:0]  tok_w;
  logic [DEPTH-1:0]  passed_w;
  logic [DEPTH-1:0]  hit_w;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;
  assign hit_any   = |hit_w;

  // gather the tail entry; at most one cell drives a nonzero word
  always_comb begin
    tail_any = '0;
    for (int i = 0; i < DEPTH; i++) tail_any = tail_any | cell_tail[i];
  end

  // the chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    logic              tok_l, passed_r;

    if (g == 0) begin : g_head
      assign left_d = ctl.key;
      assign tok_l  = 1'b0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
      assign tok_l  = tok_w[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_d  = cell_data[g];
      assign passed_r = 1'b0;
    end else begin : g_mid_r
      assign right_d  = cell_data[g+1];
      assign passed_r = passed_w[g+1];
    end

    blsd_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .count        (count),
      .left_data    (left_d),
      .right_data   (right_d),
      .tok_in       (tok_l),
      .passed_right (passed_r),
      .data         (cell_data[g]),
      .tok          (tok_w[g]),
      .passed       (passed_w[g]),
      .hit          (hit_w[g]),
      .tail_data    (cell_tail[g])
    );
  end

  // command decode and result formation
  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.key       = (state == S_IDLE) ? $unsigned(req.data.value) : key;
    state_next    = state;
    count_next    = count;
    steps_next    = steps;
    done          = 1'b0;
    res.out_value = '0;
    res.found     = 1'b0;
    res.status    = ST_OK;

    case (state)
      S_IDLE: begin
        if (accept) begin
          done = 1'b1;
          case (req.data.mode)
            MODE_PUSH_HEAD: begin
              if (full) begin
                res.status = ST_FULL;
              end else begin
                ctl.op     = OP_SHIFT_UP;
                count_next = count + 1'b1;
              end
            end
            MODE_PUSH_TAIL: begin
              if (full) begin
                res.status = ST_FULL;
              end else begin
                ctl.op     = OP_WRITE_TAIL;
                count_next = count + 1'b1;
              end
            end
            MODE_POP_HEAD: begin
              if (empty) begin
                res.status = ST_EMPTY;
              end else begin
                ctl.op        = OP_SHIFT_DOWN;
                res.out_value = $signed(cell_data[0]);
                count_next    = count - 1'b1;
              end
            end
            MODE_POP_TAIL: begin
              if (empty) begin
                res.status = ST_EMPTY;
              end else begin
                res.out_value = $signed(tail_any);
                count_next    = count - 1'b1;
              end
            end
            MODE_DELETE, MODE_CONTAINS: begin
              // empty list: nothing to search, answer now
              if (!empty) begin
                done       = 1'b0;
                ctl.op     = OP_SCAN_START;
                steps_next = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.op     = OP_SCAN_STEP;
        steps_next = steps + 1'b1;
        if (hit_any) begin
          if (is_del) begin
            state_next = S_DEL;
          end else begin
            done       = 1'b1;
            res.found  = 1'b1;
            state_next = S_IDLE;
          end
        end else if (steps + 1'b1 == count) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DEL: begin
        ctl.op     = OP_DEL_SHIFT;
        count_next = count - 1'b1;
        done       = 1'b1;
        res.found  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      steps     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      steps <= steps_next;
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      key    <= $unsigned(req.data.value);
      is_del <= (req.data.mode == MODE_DELETE);
    end
    if (done) rsp_data <= res;
  end

  // the list never holds more than DEPTH entries
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  // a push into a full list leaves the count alone
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && full &&
    (req.data.mode == MODE_PUSH_HEAD || req.data.mode == MODE_PUSH_TAIL)
    |=> $stable(count))
    else $error("push into full list changed count");

  // the search never walks past the last valid entry
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> steps < count)
    else $error("search walked past tail");

  // a delete step always ends with a result and one entry fewer
  a_del_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DEL |=> rsp_valid && state == S_IDLE && count == $past(count) - 1'b1)
    else $error("delete did not complete");

  // no request is taken while a search is running
  a_scan_block: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !accept)
    else $error("request taken during search");

endmodule

`default_nettype wire

[bench/tb_bounded_list_with_search_delete.sv]
// Testbench for bounded_list_with_search_delete: random and directed list traffic with a scoreboard.
`default_nettype none

module tb_bounded_list_with_search_delete;
  import blsd_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  // Modes outside the defined set; the block must answer them as a no-op.
  localparam logic [2:0] MODE_NOP_6 = 3'd6;
  localparam logic [2:0] MODE_NOP_7 = 3'd7;
  localparam int ITEMS_PER_PHASE = 450;
  // Longest search walks every cell, plus a margin for the output register.
  localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;

  typedef enum int {EP_GROW, EP_SHRINK, EP_SEARCH, EP_MIXED} episode_t;

  // Mirror of the list contents; predicts one result per request transfer and
  // checks results in order.
  class list_scoreboard;
    logic signed [DATA_W-1:0] slots [LIST_DEPTH];
    int unsigned fill;
    rsp_t pending_rsp [$];
    int errors;
    int checked;
    int mode_hits [8];
    int full_hits;
    int empty_hits;
    int found_hits;

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      full_hits = 0;
      empty_hits = 0;
      found_hits = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
    endfunction

    function void remove_slot(int unsigned pos);
      int unsigned i;
      for (i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
      fill--;
    endfunction

    function logic signed [DATA_W-1:0] pick_stored();
      if (fill == 0) return '0;
      return slots[$urandom_range(fill - 1)];
    endfunction

    // Apply one accepted request to the mirror and queue its expected result.
    function void note_request(req_t r);
      rsp_t e;
      int unsigned i;
      int unsigned pos;
      e = '0;
      e.status = ST_OK;
      pos = fill;
      mode_hits[r.mode]++;
      case (r.mode)
        MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
          if (fill >= LIST_DEPTH) begin
            e.status = ST_FULL;
          end else if (r.mode == MODE_PUSH_HEAD) begin
            for (i = fill; i > 0; i--) slots[i] = slots[i - 1];
            slots[0] = r.value;
            fill++;
          end else begin
            slots[fill] = r.value;
            fill++;
          end
        end
        MODE_POP_HEAD, MODE_POP_TAIL: begin
          if (fill == 0) begin
            e.status = ST_EMPTY;
          end else if (r.mode == MODE_POP_HEAD) begin
            e.out_value = slots[0];
            remove_slot(0);
          end else begin
            e.out_value = slots[fill - 1];
            fill--;
          end
        end
        MODE_DELETE, MODE_CONTAINS: begin
          for (i = 0; i < fill && pos == fill; i++)
            if (slots[i] == r.value) pos = i;
          if (pos < fill) begin
            e.found = 1'b1;
            if (r.mode == MODE_DELETE) remove_slot(pos);
          end
        end
        default: ;
      endcase
      e.count = fill[4:0];
      if (e.status == ST_FULL) full_hits++;
      if (e.status == ST_EMPTY) empty_hits++;
      if (e.found) found_hits++;
      pending_rsp.push_back(e);
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none, actual %0d/%0d/%0d/%0d",
                 $time, got.out_value, got.found, got.status, got.count);
        return;
      end
      e = pending_rsp.pop_front();
      checked++;
      compare_field("out_value", e.out_value, got.out_value);
      compare_field("found", e.found, got.found);
      compare_field("status", e.status, got.status);
      compare_field("count", e.count, got.count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int tx_idle_pct;
  int rx_idle_pct;
  list_scoreboard sb;

  blsd_chan_if #(.payload_t(req_t)) req_if ();
  blsd_chan_if #(.payload_t(rsp_t)) rsp_if ();

  bounded_list_with_search_delete #(.DEPTH(LIST_DEPTH)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random; change ready only at the falling edge.
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
  end

  // Drive one request: idle at random first, then hold valid until the
  // transfer. Leave valid high on return so back-to-back requests need no
  // lowering; the next call or a drain decides.
  task automatic send_request(input logic [2:0] m, input logic signed [DATA_W-1:0] v);
    req_t r;
    r.mode = m;
    r.value = v;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Hold off the request side until every predicted result has come back.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (sb.pending_rsp.size() != 0);
  endtask

  // Mostly small values and values already stored so that searches hit;
  // the rest are extremes and full-width random words.
  function automatic logic signed [DATA_W-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) return $signed($urandom_range(7)) - 4;
    if (pick < 65) return sb.pick_stored();
    if (pick < 75) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom();
  endfunction

  // Bias the operation mix by episode so the list swings between empty and
  // full, with search-heavy stretches in between.
  function automatic logic [2:0] random_mode(episode_t ep);
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    roll = $urandom_range(99);
    if (roll < 2) return (roll == 0) ? MODE_NOP_6 : MODE_NOP_7;
    case (ep)
      EP_GROW: begin
        push_pct = 70;
        pop_pct = 15;
      end
      EP_SHRINK: begin
        push_pct = 15;
        pop_pct = 70;
      end
      EP_SEARCH: begin
        push_pct = 20;
        pop_pct = 10;
      end
      default: begin
        push_pct = 35;
        pop_pct = 30;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < push_pct) return $urandom_range(1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD;
    if (roll < push_pct + pop_pct) return $urandom_range(1) ? MODE_POP_TAIL : MODE_POP_HEAD;
    return $urandom_range(1) ? MODE_DELETE : MODE_CONTAINS;
  endfunction

  // Run a block of random episodes at one idle setting, then drain.
  task automatic run_phase(input int tx_pct, input int rx_pct, input int items);
    int sent;
    int left;
    episode_t ep;
    logic [2:0] m;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < items) begin
      ep = episode_t'($urandom_range(3));
      left = $urandom_range(60, 15);
      while (left > 0 && sent < items) begin
        m = random_mode(ep);
        send_request(m, random_value());
        left--;
        // No-op modes are sent but do not advance the item count.
        if (m != MODE_NOP_6 && m != MODE_NOP_7) sent++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    sb = new();
    req_if.valid = 1'b0;
    req_if.data = '0;
    tx_idle_pct = 17;
    rx_idle_pct = 68;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Empty-list cases: pops flag empty, searches miss, unused modes no-op.
    send_request(MODE_POP_HEAD, 0);
    send_request(MODE_POP_TAIL, 0);
    send_request(MODE_DELETE, 5);
    send_request(MODE_CONTAINS, 5);
    send_request(MODE_NOP_6, -1);
    send_request(MODE_NOP_7, 32'sh8000_0000);
    // Build 0, min, max, -1 from both ends.
    send_request(MODE_PUSH_HEAD, 32'sh8000_0000);
    send_request(MODE_PUSH_TAIL, 32'sh7fff_ffff);
    send_request(MODE_PUSH_HEAD, 0);
    send_request(MODE_PUSH_TAIL, -1);
    // Hit at the tail after a full walk, then misses on a non-empty list.
    send_request(MODE_CONTAINS, -1);
    send_request(MODE_CONTAINS, 1);
    send_request(MODE_DELETE, 1);
    // Delete at the head, then in the middle.
    send_request(MODE_DELETE, 0);
    send_request(MODE_DELETE, 32'sh7fff_ffff);
    send_request(MODE_POP_TAIL, 0);
    send_request(MODE_POP_HEAD, 0);
    // Delete the only entry, which is also the head.
    send_request(MODE_PUSH_TAIL, 42);
    send_request(MODE_DELETE, 42);
    wait_for_results();

    run_phase(17, 68, ITEMS_PER_PHASE);
    run_phase(68, 17, ITEMS_PER_PHASE);
    run_phase(0, 0, ITEMS_PER_PHASE);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d results: push %0d/%0d, pop %0d/%0d, delete %0d, contains %0d, no-op %0d",
             sb.checked, sb.mode_hits[MODE_PUSH_HEAD], sb.mode_hits[MODE_PUSH_TAIL],
             sb.mode_hits[MODE_POP_HEAD], sb.mode_hits[MODE_POP_TAIL],
             sb.mode_hits[MODE_DELETE], sb.mode_hits[MODE_CONTAINS],
             sb.mode_hits[MODE_NOP_6] + sb.mode_hits[MODE_NOP_7]);
    $display("Pushes refused as full %0d, pops on empty %0d, search hits %0d",
             sb.full_hits, sb.empty_hits, sb.found_hits);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal completion.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
